// ===== hw/rtl/bfa_pkg.sv =====
// ----------------------------------------------------------------------------
// bfa_pkg
// Shared types and constants of the bump frame allocator: request kinds,
// controller states, result selects and the command and status bundles.
// ----------------------------------------------------------------------------
package bfa_pkg;

  localparam int ADDR_W       = 64;
  localparam int KIND_W       = 3;
  localparam int STATUS_W     = 2;
  localparam int CFG_IDX_W    = 2;

  // defaults; the frame size must be a power of two
  localparam int MAX_REGIONS_DEF = 32;
  localparam int FRAME_BYTES_DEF = 4096;

  localparam logic [CFG_IDX_W-1:0] CFG_DATA_FLOOR = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_END  = 2'd1;

  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EXHAUSTED = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NO_MAP    = 2'd2;

  typedef enum logic [KIND_W-1:0] {
    KIND_CLEAR  = 3'd0,
    KIND_APPEND = 3'd1,
    KIND_START  = 3'd2,
    KIND_TAKE   = 3'd3,
    KIND_BRK    = 3'd4
  } kind_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CLEAR,
    S_APPEND,
    S_START,
    S_BUMP,
    S_CHECK,
    S_EVAL,
    S_FINISH
  } state_t;

  typedef enum logic [1:0] {
    OUT_ZERO,
    OUT_CURSOR,
    OUT_TAKEN,
    OUT_NO_MAP
  } out_sel_t;

  typedef struct packed {
    logic     cap_in;      // capture payload of an accepted transaction
    logic     clear;       // empty the region table
    logic     append;      // write captured region at the fill count
    logic     start_init;  // cursor to the higher floor, rewind index
    logic     bump;        // remember cursor, step one frame
    logic     eval;        // raise cursor to region start, step index on miss
    logic     set_exh;     // walked off the table
    logic     load_out;    // load the result register
    out_sel_t out_sel;
  } cmd_t;

  typedef struct packed {
    logic count_zero;
    logic full;
    logic index_lt_count;
    logic hit;
    logic exhausted;
    logic out_free;
  } stat_t;

endpackage

// ===== hw/rtl/bfa_ctrl.sv =====
// ----------------------------------------------------------------------------
// bfa_ctrl
// Controller of the bump frame allocator: takes a transaction, sequences the
// region walk in the datapath and hands the result to the output register.
// ----------------------------------------------------------------------------
module bfa_ctrl (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [bfa_pkg::KIND_W-1:0]   kind,
  input  bfa_pkg::stat_t               stat,
  output bfa_pkg::cmd_t                cmd
);
  import bfa_pkg::*;

  state_t              state;
  state_t              state_next;
  logic [KIND_W-1:0]   kind_q;
  logic                found;
  logic                accept;

  assign accept = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      kind_q <= KIND_BRK;
      found  <= 1'b0;
    end else begin
      state <= state_next;
      if (accept) begin
        kind_q <= kind;
        found  <= 1'b0;
      end else if (state == S_EVAL && stat.hit) begin
        found <= 1'b1;
      end
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          case (kind)
            KIND_CLEAR:  state_next = S_CLEAR;
            KIND_APPEND: state_next = S_APPEND;
            KIND_START:  state_next = stat.count_zero ? S_FINISH : S_START;
            KIND_TAKE:   state_next = stat.exhausted ? S_FINISH : S_BUMP;
            default:     state_next = S_FINISH;
          endcase
        end
      end
      S_CLEAR:  state_next = S_FINISH;
      S_APPEND: state_next = S_FINISH;
      S_START:  state_next = S_CHECK;
      S_BUMP:   state_next = S_CHECK;
      S_CHECK:  state_next = stat.index_lt_count ? S_EVAL : S_FINISH;
      S_EVAL:   state_next = stat.hit ? S_FINISH : S_CHECK;
      S_FINISH: begin
        if (stat.out_free) state_next = S_IDLE;
      end
      default:  state_next = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready       = 1'b0;
    cmd            = '0;
    cmd.out_sel    = OUT_ZERO;
    unique case (state)
      S_IDLE: begin
        in_ready   = 1'b1;
        cmd.cap_in = in_valid;
      end
      S_CLEAR:  cmd.clear      = 1'b1;
      S_APPEND: cmd.append     = !stat.full;
      S_START:  cmd.start_init = 1'b1;
      S_BUMP:   cmd.bump       = 1'b1;
      S_CHECK:  cmd.set_exh    = !stat.index_lt_count;
      S_EVAL:   cmd.eval       = 1'b1;
      S_FINISH: begin
        cmd.load_out = stat.out_free;
        case (kind_q)
          KIND_START: cmd.out_sel = stat.count_zero ? OUT_NO_MAP : OUT_CURSOR;
          KIND_TAKE:  cmd.out_sel = found ? OUT_TAKEN : OUT_ZERO;
          KIND_BRK:   cmd.out_sel = OUT_CURSOR;
          default:    cmd.out_sel = OUT_ZERO;
        endcase
      end
      default: ;
    endcase
  end

endmodule

// ===== hw/rtl/bfa_datapath.sv =====
// ----------------------------------------------------------------------------
// bfa_datapath
// Region table memory, cursor, walk index, floors and the result register of
// the bump frame allocator.
// ----------------------------------------------------------------------------
module bfa_datapath #(
  parameter int MAX_REGIONS = bfa_pkg::MAX_REGIONS_DEF,
  parameter int FRAME_BYTES = bfa_pkg::FRAME_BYTES_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_write,
  input  logic [bfa_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [bfa_pkg::ADDR_W-1:0]    cfg_data,
  input  logic [bfa_pkg::ADDR_W-1:0]    region_base,
  input  logic [bfa_pkg::ADDR_W-1:0]    region_length,
  input  logic                          region_usable,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [bfa_pkg::ADDR_W-1:0]    frame_address,
  output logic [bfa_pkg::STATUS_W-1:0]  status,
  input  bfa_pkg::cmd_t                 cmd,
  output bfa_pkg::stat_t                stat
);
  import bfa_pkg::*;

  localparam int IDX_W = $clog2(MAX_REGIONS + 1);
  localparam int MEM_AW = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1;
  localparam logic [ADDR_W-1:0] FRAME = ADDR_W'(FRAME_BYTES);
  localparam logic [ADDR_W-1:0] FMASK = ADDR_W'(FRAME_BYTES - 1);
  localparam logic [IDX_W-1:0]  MAX_CNT = IDX_W'(MAX_REGIONS);

  logic [ADDR_W-1:0] lo_mem   [MAX_REGIONS];
  logic [ADDR_W-1:0] hi_mem   [MAX_REGIONS];
  logic              good_mem [MAX_REGIONS];

  logic [ADDR_W-1:0] data_floor;
  logic [ADDR_W-1:0] image_end;
  logic [ADDR_W-1:0] new_lo;
  logic [ADDR_W-1:0] new_hi;
  logic              new_use;
  logic [ADDR_W-1:0] rd_lo;
  logic [ADDR_W-1:0] rd_hi;
  logic              rd_good;
  logic [IDX_W-1:0]  count;
  logic [IDX_W-1:0]  index;
  logic [ADDR_W-1:0] cursor;
  logic [ADDR_W-1:0] taken;
  logic              exhausted;
  logic              c_lt_lo;
  logic              c_lt_hi;

  always_ff @(posedge clk) begin
    if (rst) begin
      data_floor <= '0;
      image_end  <= '0;
    end else if (cfg_write) begin
      if (cfg_index == CFG_DATA_FLOOR) data_floor <= cfg_data;
      if (cfg_index == CFG_IMAGE_END)  image_end  <= cfg_data;
    end
  end

  // rounded region bounds, formed when the transaction is taken
  always_ff @(posedge clk) begin
    if (cmd.cap_in) begin
      new_lo  <= (region_base + FMASK) & ~FMASK;
      new_hi  <= (region_base + region_length) & ~FMASK;
      new_use <= region_usable;
    end
  end

  // region table, one write port at the fill count, one read at the index
  always_ff @(posedge clk) begin
    if (cmd.append) begin
      lo_mem[count[MEM_AW-1:0]]   <= new_lo;
      hi_mem[count[MEM_AW-1:0]]   <= new_hi;
      good_mem[count[MEM_AW-1:0]] <= new_use && (new_lo < new_hi);
    end
    rd_lo   <= lo_mem[index[MEM_AW-1:0]];
    rd_hi   <= hi_mem[index[MEM_AW-1:0]];
    rd_good <= good_mem[index[MEM_AW-1:0]];
  end

  assign c_lt_lo = cursor < rd_lo;
  assign c_lt_hi = cursor < rd_hi;

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      index     <= '0;
      cursor    <= '0;
      exhausted <= 1'b0;
    end else begin
      if (cmd.clear) begin
        count <= '0;
        index <= '0;
      end
      if (cmd.append) count <= count + 1'b1;
      if (cmd.start_init) begin
        cursor <= (data_floor < image_end) ? image_end : data_floor;
        index  <= '0;
      end
      if (cmd.bump) cursor <= cursor + FRAME;
      if (cmd.eval) begin
        if (c_lt_lo) cursor <= rd_lo;
        if (!stat.hit) index <= index + 1'b1;
      end
      if (cmd.set_exh) exhausted <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.bump) taken <= cursor;
  end

  // result register, free again once the transaction downstream completes
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      case (cmd.out_sel)
        OUT_CURSOR: frame_address <= cursor;
        OUT_TAKEN:  frame_address <= taken;
        default:    frame_address <= '0;
      endcase
      if (cmd.out_sel == OUT_NO_MAP) status <= ST_NO_MAP;
      else status <= exhausted ? ST_EXHAUSTED : ST_OK;
    end
  end

  assign stat.count_zero     = (count == '0);
  assign stat.full           = (count == MAX_CNT);
  assign stat.index_lt_count = (index < count);
  assign stat.hit            = rd_good && (c_lt_lo || c_lt_hi);
  assign stat.exhausted      = exhausted;
  assign stat.out_free       = !out_valid || out_ready;

endmodule

// ===== hw/rtl/memory_map_bump_frame_allocator.sv =====
// Bump frame allocator over a table of memory-map regions. Start and take
// frame walk the region table and can run off its end: the walk reads one
// table entry from the region memory and compares it against the cursor on
// the next cycle. One transaction is worked at a time; a finished result sits
// in an output register so the next transaction can be taken while it waits,
// and a new result that finds that register still full holds the controller.
// Running off the table sets a sticky exhausted status until reset.
// ----------------------------------------------------------------------------
// memory_map_bump_frame_allocator
// Top level: joins the allocator controller and datapath.
// ----------------------------------------------------------------------------
module memory_map_bump_frame_allocator #(
  parameter int MAX_REGIONS = bfa_pkg::MAX_REGIONS_DEF,
  parameter int FRAME_BYTES = bfa_pkg::FRAME_BYTES_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_write,
  input  logic [bfa_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [bfa_pkg::ADDR_W-1:0]    cfg_data,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [bfa_pkg::KIND_W-1:0]    kind,
  input  logic [bfa_pkg::ADDR_W-1:0]    region_base,
  input  logic [bfa_pkg::ADDR_W-1:0]    region_length,
  input  logic                          region_usable,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [bfa_pkg::ADDR_W-1:0]    frame_address,
  output logic [bfa_pkg::STATUS_W-1:0]  status
);
  import bfa_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  bfa_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .kind     (kind),
    .stat     (stat),
    .cmd      (cmd)
  );

  bfa_datapath #(
    .MAX_REGIONS (MAX_REGIONS),
    .FRAME_BYTES (FRAME_BYTES)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cfg_write     (cfg_write),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .region_base   (region_base),
    .region_length (region_length),
    .region_usable (region_usable),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .frame_address (frame_address),
    .status        (status),
    .cmd           (cmd),
    .stat          (stat)
  );

endmodule
